>>> src/fdsa_pkg.sv
// Package: stack sizes, word codes, error codes and channel payload types.
package fdsa_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int CELL_WIDTH  = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [4:0] ACT_PUSH  = 5'd0;
  localparam logic [4:0] ACT_DROP  = 5'd1;
  localparam logic [4:0] ACT_DUP   = 5'd2;
  localparam logic [4:0] ACT_SWAP  = 5'd3;
  localparam logic [4:0] ACT_ROT   = 5'd4;
  localparam logic [4:0] ACT_AND   = 5'd5;
  localparam logic [4:0] ACT_LAND  = 5'd6;
  localparam logic [4:0] ACT_OR    = 5'd7;
  localparam logic [4:0] ACT_LOR   = 5'd8;
  localparam logic [4:0] ACT_NOT   = 5'd9;
  localparam logic [4:0] ACT_LNOT  = 5'd10;
  localparam logic [4:0] ACT_SHL   = 5'd11;
  localparam logic [4:0] ACT_SHR   = 5'd12;
  localparam logic [4:0] ACT_ADD   = 5'd13;
  localparam logic [4:0] ACT_SUB   = 5'd14;
  localparam logic [4:0] ACT_MUL   = 5'd15;
  localparam logic [4:0] ACT_UDIV  = 5'd16;
  localparam logic [4:0] ACT_SDIV  = 5'd17;
  localparam logic [4:0] ACT_SMUL  = 5'd18;
  localparam logic [4:0] ACT_DEPTH = 5'd19;
  localparam logic [4:0] ACT_PEEK  = 5'd20;
  localparam logic [4:0] ACT_RESET = 5'd21;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_DIV0  = 2'd3;

  typedef struct packed {
    logic [4:0]  action;
    logic [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [6:0]  stack_depth;
    logic [1:0]  error_code;
  } out_item_t;

  // Decoded word handed from the front end to the execution unit.
  typedef struct packed {
    logic [4:0]            action;
    logic [CELL_WIDTH-1:0] value;
    logic [1:0]            need;
  } cmd_t;

endpackage

>>> src/fdsa_front.sv
// Front end: accepts words, classifies operand count, and queues them.
module fdsa_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fdsa_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output fdsa_pkg::cmd_t    cmd_data
);
  import fdsa_pkg::*;

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r;
  cmd_t              cls;
  logic              push, pop;

  always_comb begin
    cls.action = in_data.action;
    cls.value  = in_data.push_value[CELL_WIDTH-1:0];
    case (in_data.action)
      ACT_DROP, ACT_DUP, ACT_NOT, ACT_LNOT, ACT_PEEK: cls.need = 2'd1;
      ACT_SWAP, ACT_AND, ACT_LAND, ACT_OR, ACT_LOR, ACT_SHL, ACT_SHR,
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_UDIV, ACT_SDIV, ACT_SMUL: cls.need = 2'd2;
      ACT_ROT: cls.need = 2'd3;
      default: cls.need = 2'd0;
    endcase
  end

  assign in_stall  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd_data  = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= cls;
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

>>> src/fdsa_div.sv
// Iterative restoring divider, one quotient bit per cycle, signed or unsigned.
module fdsa_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            is_signed,
  input  logic [fdsa_pkg::CELL_WIDTH-1:0] num,
  input  logic [fdsa_pkg::CELL_WIDTH-1:0] den,
  output logic                            done,
  output logic [fdsa_pkg::CELL_WIDTH-1:0] quot
);
  import fdsa_pkg::*;

  localparam int CW = $clog2(CELL_WIDTH + 1);

  logic [CELL_WIDTH-1:0] q_r, d_r, rem_r;
  logic [CW-1:0]         cnt_r;
  logic                  neg_r, busy_r;
  logic [CELL_WIDTH:0]   trial;
  logic [CELL_WIDTH-1:0] an, ad;
  logic                  nn, dn;

  assign nn    = is_signed && num[CELL_WIDTH-1];
  assign dn    = is_signed && den[CELL_WIDTH-1];
  assign an    = nn ? (~num + 1'b1) : num;
  assign ad    = dn ? (~den + 1'b1) : den;
  assign trial = {rem_r, q_r[CELL_WIDTH-1]} - {1'b0, d_r};
  assign done  = busy_r && (cnt_r == '0);
  assign quot  = neg_r ? (~q_r + 1'b1) : q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= an;
      d_r   <= ad;
      rem_r <= '0;
      neg_r <= nn ^ dn;
    end else if (busy_r && cnt_r != '0) begin
      if (!trial[CELL_WIDTH]) begin
        rem_r <= trial[CELL_WIDTH-1:0];
        q_r   <= {q_r[CELL_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[CELL_WIDTH-2:0], q_r[CELL_WIDTH-1]};
        q_r   <= {q_r[CELL_WIDTH-2:0], 1'b0};
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(CELL_WIDTH);
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> src/fdsa_back.sv
// Back end: reads operands from the stack memory, executes a word, writes back.
module fdsa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_take,
  input  fdsa_pkg::cmd_t      cmd_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fdsa_pkg::out_item_t out_data
);
  import fdsa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [CELL_WIDTH-1:0] mem [STACK_DEPTH];
  logic [2:0]            st_r, st_nxt;
  logic [SP_W-1:0]       sp_r;
  cmd_t                  cmd_r;
  logic [1:0]            rd_idx_r, wr_idx_r;
  logic [CELL_WIDTH-1:0] opa_r, opb_r, opc_r, rdata_r;
  logic [CELL_WIDTH-1:0] res_r, w0_r, w1_r, w2_r;
  logic [SP_W-1:0]       nsp_r;
  logic [1:0]            err_r, nwr_r;
  logic                  ov_r;
  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  logic                  div_start, div_done;
  logic [CELL_WIDTH-1:0] div_q;
  logic [CELL_WIDTH-1:0] a, b, c, r;
  logic                  shl_big;
  logic                  ok_under, full;

  fdsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .is_signed(cmd_r.action == ACT_SDIV),
    .num      (opa_r),
    .den      (opb_r),
    .done     (div_done),
    .quot     (div_q)
  );

  assign cmd_take = (st_r == S_IDLE) && !ov_r;
  assign ok_under = (sp_r >= SP_W'(cmd_r.need));
  assign full     = (sp_r == SP_W'(STACK_DEPTH));
  assign a = opa_r;
  assign b = opb_r;
  assign c = opc_r;
  assign shl_big = (b >= CELL_WIDTH);
  assign div_start = (st_r == S_EXEC) && ok_under && (b != '0) &&
                     (cmd_r.action == ACT_UDIV || cmd_r.action == ACT_SDIV);

  // Read operands one per cycle: top, then second, then third.
  assign rd_addr = ADDR_W'(sp_r - SP_W'(rd_idx_r) - 1'b1);
  // Write back deepest first: slot (new sp - nwr + wr_idx).
  assign wr_addr = ADDR_W'(nsp_r - SP_W'(nwr_r) + SP_W'(wr_idx_r));

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (st_r == S_WB && wr_idx_r < nwr_r)
      mem[wr_addr] <= (wr_idx_r == 2'd0) ? w0_r : (wr_idx_r == 2'd1) ? w1_r : w2_r;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (cmd_valid && !ov_r) st_nxt = S_RD;
      S_RD:   if (rd_idx_r == cmd_r.need || !ok_under) st_nxt = S_EXEC;
      S_EXEC: st_nxt = div_start ? S_DIV : S_WB;
      S_DIV:  if (div_done) st_nxt = S_WB;
      S_WB:   if (wr_idx_r >= nwr_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    case (cmd_r.action)
      ACT_AND:  r = a & b;
      ACT_LAND: r = (a != '0 && b != '0) ? '1 : '0;
      ACT_OR:   r = a | b;
      ACT_LOR:  r = (a != '0 || b != '0) ? '1 : '0;
      ACT_SHL:  r = shl_big ? '0 : (a << b);
      ACT_SHR:  r = shl_big ? '0 : (a >> b);
      ACT_ADD:  r = a + b;
      ACT_SUB:  r = a - b;
      default:  r = CELL_WIDTH'(a * b);
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && cmd_valid && !ov_r) begin
      cmd_r    <= cmd_data;
      rd_idx_r <= '0;
    end
    if (st_r == S_RD) begin
      rd_idx_r <= rd_idx_r + 1'b1;
      // read data is registered and arrives in the cycle after its address
      case (rd_idx_r)
        2'd1: opb_r <= rdata_r;
        2'd2: opa_r <= rdata_r;
        2'd3: opc_r <= rdata_r;
        default: ;
      endcase
    end
    if (st_r == S_EXEC) begin
      wr_idx_r <= '0;
      nsp_r    <= sp_r;
      nwr_r    <= '0;
      err_r    <= ERR_OK;
      res_r    <= '0;
      if (!ok_under) begin
        err_r <= ERR_UNDER;
      end else begin
        case (cmd_r.action)
          ACT_PUSH: if (full) err_r <= ERR_OVER;
            else begin
              res_r <= cmd_r.value; w0_r <= cmd_r.value;
              nsp_r <= sp_r + 1'b1; nwr_r <= 2'd1;
            end
          ACT_DUP: if (full) err_r <= ERR_OVER;
            else begin
              res_r <= b; w0_r <= b; nsp_r <= sp_r + 1'b1; nwr_r <= 2'd1;
            end
          ACT_DROP: begin res_r <= b; nsp_r <= sp_r - 1'b1; end
          ACT_SWAP: begin res_r <= a; w0_r <= b; w1_r <= a; nwr_r <= 2'd2; end
          ACT_ROT: begin
            res_r <= c; w0_r <= a; w1_r <= b; w2_r <= c; nwr_r <= 2'd3;
          end
          ACT_NOT: begin res_r <= ~b; w0_r <= ~b; nwr_r <= 2'd1; end
          ACT_LNOT: begin
            res_r <= (b == '0) ? '1 : '0; w0_r <= (b == '0) ? '1 : '0;
            nwr_r <= 2'd1;
          end
          ACT_DEPTH: res_r <= CELL_WIDTH'(sp_r);
          ACT_PEEK:  res_r <= b;
          ACT_RESET: nsp_r <= '0;
          ACT_UDIV, ACT_SDIV: begin
            if (b == '0) err_r <= ERR_DIV0;
            else begin nsp_r <= sp_r - 1'b1; nwr_r <= 2'd1; end
          end
          ACT_AND, ACT_LAND, ACT_OR, ACT_LOR, ACT_SHL, ACT_SHR, ACT_ADD,
          ACT_SUB, ACT_MUL, ACT_SMUL: begin
            res_r <= r; w0_r <= r; nsp_r <= sp_r - 1'b1; nwr_r <= 2'd1;
          end
          default: ;
        endcase
      end
    end
    if (st_r == S_DIV && div_done) begin
      res_r <= div_q;
      w0_r  <= div_q;
    end
    if (st_r == S_WB) wr_idx_r <= wr_idx_r + 1'b1;
    if (st_r == S_WB && st_nxt == S_IDLE) begin
      out_data.result_value <= res_r;
      out_data.stack_depth  <= 7'(nsp_r);
      out_data.error_code   <= err_r;
    end
    if (!rst_n) begin
      st_r <= S_IDLE;
      sp_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_WB && st_nxt == S_IDLE) begin
        sp_r <= nsp_r;
        ov_r <= 1'b1;
      end else if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;

endmodule

>>> src/forth_data_stack_alu_top.sv
// Top level: Forth data stack with word queue and execution unit.
//  channel | dir | handshake              | payload
//  in      | in  | in_valid / in_stall    | in_data   (action, push_value)
//  out     | out | out_valid / out_stall  | out_data  (result, depth, error)
// A word passes through the take, read, execute and write-back states; the
// read state reads each operand cell and the write-back state writes each
// cell changed. Divides also wait in the bit-serial divider. The next word is
// taken only after the result has transferred. A two-entry queue keeps taking
// words while one runs.
// Reset is synchronous and empties the stack; the cells are not cleared.
// A held result stalls the execution unit only; the queue still fills.
module forth_data_stack_alu_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fdsa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fdsa_pkg::out_item_t out_data
);
  import fdsa_pkg::*;

  cmd_t cmd_data;
  logic cmd_valid, cmd_take;

  fdsa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd_data (cmd_data)
  );

  fdsa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd_data (cmd_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
